/* hdl/whc_pkg.sv */
package whc_pkg;

  localparam int unsigned DEPTH_DEF      = 32;
  localparam int unsigned ANGLE_BITS_DEF = 16;
  localparam int unsigned TIME_BITS_DEF  = 32;

  localparam int unsigned CFG_BITS     = 32;
  localparam int unsigned CFG_IDX_BITS = 1;
  localparam logic [CFG_IDX_BITS-1:0] REG_MEMORY_WINDOW  = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_GRACE_INTERVAL = 1'd1;
  localparam logic [CFG_BITS-1:0] MEMORY_WINDOW_RST  = 32'd30;
  localparam logic [CFG_BITS-1:0] GRACE_INTERVAL_RST = 32'd2;

  localparam int unsigned XW           = 64;
  localparam int unsigned ZW           = 34;
  localparam int unsigned CORDIC_ITERS = 30;
  localparam int unsigned IT_BITS      = 5;
  localparam logic signed [XW-1:0] CORDIC_K = 64'sd652032874;

  typedef struct packed {
    logic                   load;
    logic                   step;
    logic                   vec;
    logic signed [XW-1:0]   x0;
    logic signed [XW-1:0]   y0;
    logic signed [ZW-1:0]   z0;
  } cordic_cmd_t;

  function automatic logic [29:0] atan_lut(input logic [IT_BITS-1:0] i);
    logic [29:0] v;
    unique case (i)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10679838;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      5'd24: v = 30'd41;
      5'd25: v = 30'd20;
      5'd26: v = 30'd10;
      5'd27: v = 30'd5;
      5'd28: v = 30'd3;
      5'd29: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

/* hdl/whc_in_if.sv */
interface whc_in_if #(
  parameter int unsigned ANGLE_BITS = whc_pkg::ANGLE_BITS_DEF,
  parameter int unsigned TIME_BITS  = whc_pkg::TIME_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [ANGLE_BITS-1:0] heading_in;
  logic [TIME_BITS-1:0]  time_now;

  modport source (output valid, heading_in, time_now, input ready);
  modport sink   (input valid, heading_in, time_now, output ready);
endinterface

/* hdl/whc_out_if.sv */
interface whc_out_if #(
  parameter int unsigned ANGLE_BITS = whc_pkg::ANGLE_BITS_DEF,
  parameter int unsigned CNT_BITS   = 6
);
  logic                  valid;
  logic                  ready;
  logic [ANGLE_BITS-1:0] mean_heading;
  logic                  any_counted;
  logic [CNT_BITS-1:0]   samples_held;
  logic                  dropped_oldest;

  modport source (output valid, mean_heading, any_counted, samples_held, dropped_oldest,
                  input ready);
  modport sink   (input valid, mean_heading, any_counted, samples_held, dropped_oldest,
                  output ready);
endinterface

/* hdl/whc_cordic.sv */
module whc_cordic (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  whc_pkg::cordic_cmd_t               cmd_i,
  output logic signed [whc_pkg::XW-1:0]      x_o,
  output logic signed [whc_pkg::XW-1:0]      y_o,
  output logic [31:0]                        z_o,
  output logic                               last_o
);

  logic signed [whc_pkg::XW-1:0] x_q, x_d, y_q, y_d, xs, ys;
  logic signed [whc_pkg::ZW-1:0] z_q, z_d, a;
  logic [whc_pkg::IT_BITS-1:0]   it_q, it_d;
  logic                          vec_q, vec_d, ccw;

  assign xs  = x_q >>> it_q;
  assign ys  = y_q >>> it_q;
  assign a   = $signed({{(whc_pkg::ZW-30){1'b0}}, whc_pkg::atan_lut(it_q)});
  assign ccw = vec_q ? !(y_q > 0) : !z_q[whc_pkg::ZW-1];

  always_comb begin
    x_d   = x_q;
    y_d   = y_q;
    z_d   = z_q;
    it_d  = it_q;
    vec_d = vec_q;
    if (cmd_i.load) begin
      x_d   = cmd_i.x0;
      y_d   = cmd_i.y0;
      z_d   = cmd_i.z0;
      it_d  = '0;
      vec_d = cmd_i.vec;
    end else if (cmd_i.step) begin
      if (ccw) begin
        x_d = x_q - ys;
        y_d = y_q + xs;
        z_d = z_q - a;
      end else begin
        x_d = x_q + ys;
        y_d = y_q - xs;
        z_d = z_q + a;
      end
      it_d = it_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      it_q  <= '0;
      vec_q <= 1'b0;
    end else begin
      it_q  <= it_d;
      vec_q <= vec_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign x_o    = x_q;
  assign y_o    = y_q;
  assign z_o    = z_q[31:0];
  assign last_o = (it_q == whc_pkg::IT_BITS'(whc_pkg::CORDIC_ITERS - 1));

endmodule

/* hdl/windowed_circular_heading_mean_top.sv */
// Sliding-window circular mean of heading samples. Each transfer on the input channel stores
// one heading with its timestamp in a ring of DEPTH entries, evicts entries older than
// memory_window, and returns the atan2 of the summed sine and cosine of entries older than
// grace_interval. The block takes one sample at a time: it accepts no new input transfer until
// the result of the last one has been registered for output. Each sample is paced by the single
// ring read port, read once per entry in each of the eviction and grace passes, and by the shared
// 30-step CORDIC unit, used once per counted entry and once for the final atan2 unless both sums
// are zero. A result that the receiver does not take adds its wait.
// The ring needs no clearing after reset.
module windowed_circular_heading_mean_top #(
  parameter int unsigned DEPTH      = whc_pkg::DEPTH_DEF,
  parameter int unsigned ANGLE_BITS = whc_pkg::ANGLE_BITS_DEF,
  parameter int unsigned TIME_BITS  = whc_pkg::TIME_BITS_DEF,
  parameter int unsigned CNT_BITS   = $clog2(DEPTH + 1)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [whc_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [whc_pkg::CFG_BITS-1:0]      cfg_data_i,
  whc_in_if.sink                            in_if,
  whc_out_if.source                         out_if
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned SW = IW + 2;
  localparam int unsigned AW = (TIME_BITS > 32) ? TIME_BITS : 32;
  localparam int unsigned MW = ANGLE_BITS + TIME_BITS;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_STALE_RD = 4'd1;
  localparam logic [3:0] S_STALE_CK = 4'd2;
  localparam logic [3:0] S_EVICT    = 4'd3;
  localparam logic [3:0] S_GR_RD    = 4'd4;
  localparam logic [3:0] S_GR_CK    = 4'd5;
  localparam logic [3:0] S_ROT      = 4'd6;
  localparam logic [3:0] S_ACC      = 4'd7;
  localparam logic [3:0] S_VEC_INIT = 4'd8;
  localparam logic [3:0] S_VEC      = 4'd9;
  localparam logic [3:0] S_OUT      = 4'd10;

  function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] a, input logic [CNT_BITS-1:0] b);
    logic [SW-1:0] s;
    s = SW'(a) + SW'(b);
    if (s >= SW'(DEPTH)) s = s - SW'(DEPTH);
    return s[IW-1:0];
  endfunction

  logic [MW-1:0] ring [DEPTH];
  logic [MW-1:0] rd_q;

  logic [whc_pkg::CFG_BITS-1:0] mw_q, gi_q;
  logic [3:0]                   st_q, st_d;
  logic [IW-1:0]                old_q, old_d, ptr_q, ptr_d;
  logic [CNT_BITS-1:0]          cnt_q, cnt_d, k_q, k_d, stale_q, stale_d;
  logic [TIME_BITS-1:0]         now_q, now_d;
  logic                         drop_q, drop_d, any_q, any_d;
  logic [1:0]                   quad_q, quad_d;
  logic signed [whc_pkg::XW-1:0] cs_q, cs_d, ss_q, ss_d, co, si;
  logic                         ov_q, ov_d;
  logic [ANGLE_BITS-1:0]        mean_q, mean_d;
  logic                         oany_q, oany_d, odrop_q, odrop_d;
  logic [CNT_BITS-1:0]          ocnt_q, ocnt_d;

  logic                         full, wr_en, last_k;
  logic [IW-1:0]                acc_old, wslot;
  logic [CNT_BITS-1:0]          acc_cnt;
  logic [TIME_BITS-1:0]         age;
  logic [AW-1:0]                age_x;
  logic [31:0]                  ph, rnd;

  whc_pkg::cordic_cmd_t         cmd;
  logic signed [whc_pkg::XW-1:0] cx, cy;
  logic [31:0]                  cz;
  logic                         clast;

  whc_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .x_o    (cx),
    .y_o    (cy),
    .z_o    (cz),
    .last_o (clast)
  );

  assign in_if.ready = (st_q == S_IDLE);
  assign full    = (cnt_q == CNT_BITS'(DEPTH));
  assign acc_old = full ? wrap_add(old_q, CNT_BITS'(1)) : old_q;
  assign acc_cnt = full ? CNT_BITS'(DEPTH - 1) : cnt_q;
  assign wslot   = wrap_add(acc_old, acc_cnt);
  assign wr_en   = in_if.valid && in_if.ready;

  assign age    = now_q - rd_q[TIME_BITS-1:0];
  assign age_x  = AW'(age);
  assign last_k = (k_q == cnt_q - 1'b1);
  assign ph     = {rd_q[MW-1 -: ANGLE_BITS], {(32 - ANGLE_BITS){1'b0}}};
  assign rnd    = cz + (32'd1 << (31 - ANGLE_BITS));

  always_comb begin
    unique case (quad_q)
      2'd0:    begin co = cx;  si = cy;  end
      2'd1:    begin co = -cy; si = cx;  end
      2'd2:    begin co = -cx; si = -cy; end
      default: begin co = cy;  si = -cx; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) ring[wslot] <= {in_if.heading_in, in_if.time_now};
    rd_q <= ring[ptr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mw_q <= whc_pkg::MEMORY_WINDOW_RST;
      gi_q <= whc_pkg::GRACE_INTERVAL_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        whc_pkg::REG_MEMORY_WINDOW:  mw_q <= cfg_data_i;
        whc_pkg::REG_GRACE_INTERVAL: gi_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    st_d    = st_q;
    old_d   = old_q;
    ptr_d   = ptr_q;
    cnt_d   = cnt_q;
    k_d     = k_q;
    stale_d = stale_q;
    now_d   = now_q;
    drop_d  = drop_q;
    any_d   = any_q;
    quad_d  = quad_q;
    cs_d    = cs_q;
    ss_d    = ss_q;
    ov_d    = ov_q;
    mean_d  = mean_q;
    oany_d  = oany_q;
    odrop_d = odrop_q;
    ocnt_d  = ocnt_q;
    cmd     = '0;
    if (out_if.valid && out_if.ready) ov_d = 1'b0;
    unique case (st_q)
      S_IDLE: begin
        if (wr_en) begin
          old_d   = acc_old;
          ptr_d   = acc_old;
          cnt_d   = acc_cnt + 1'b1;
          drop_d  = full;
          now_d   = in_if.time_now;
          k_d     = '0;
          stale_d = '0;
          st_d    = S_STALE_RD;
        end
      end
      S_STALE_RD: st_d = S_STALE_CK;
      S_STALE_CK: begin
        if (age_x > AW'(mw_q)) stale_d = stale_q + 1'b1;
        k_d   = k_q + 1'b1;
        ptr_d = wrap_add(ptr_q, CNT_BITS'(1));
        st_d  = last_k ? S_EVICT : S_STALE_RD;
      end
      S_EVICT: begin
        old_d = wrap_add(old_q, stale_q);
        ptr_d = wrap_add(old_q, stale_q);
        cnt_d = cnt_q - stale_q;
        k_d   = '0;
        cs_d  = '0;
        ss_d  = '0;
        any_d = 1'b0;
        st_d  = S_GR_RD;
      end
      S_GR_RD: st_d = S_GR_CK;
      S_GR_CK: begin
        if (age_x > AW'(gi_q)) begin
          cmd.load = 1'b1;
          cmd.x0   = whc_pkg::CORDIC_K;
          cmd.y0   = '0;
          cmd.z0   = $signed({{(whc_pkg::ZW-30){1'b0}}, ph[29:0]});
          quad_d   = ph[31:30];
          any_d    = 1'b1;
          st_d     = S_ROT;
        end else begin
          k_d   = k_q + 1'b1;
          ptr_d = wrap_add(ptr_q, CNT_BITS'(1));
          st_d  = last_k ? S_VEC_INIT : S_GR_RD;
        end
      end
      S_ROT: begin
        cmd.step = 1'b1;
        if (clast) st_d = S_ACC;
      end
      S_ACC: begin
        cs_d  = cs_q + co;
        ss_d  = ss_q + si;
        k_d   = k_q + 1'b1;
        ptr_d = wrap_add(ptr_q, CNT_BITS'(1));
        st_d  = last_k ? S_VEC_INIT : S_GR_RD;
      end
      S_VEC_INIT: begin
        cmd.load = 1'b1;
        cmd.vec  = 1'b1;
        if (cs_q < 0) begin
          cmd.x0 = -cs_q;
          cmd.y0 = -ss_q;
          cmd.z0 = $signed(whc_pkg::ZW'(34'h080000000));
        end else begin
          cmd.x0 = cs_q;
          cmd.y0 = ss_q;
          cmd.z0 = '0;
        end
        if (cs_q == 0 && ss_q == 0) begin
          cmd.z0 = '0;
          st_d   = S_OUT;
        end else begin
          st_d   = S_VEC;
        end
      end
      S_VEC: begin
        cmd.step = 1'b1;
        if (clast) st_d = S_OUT;
      end
      S_OUT: begin
        if (!ov_q || out_if.ready) begin
          ov_d    = 1'b1;
          mean_d  = rnd[31 -: ANGLE_BITS];
          oany_d  = any_q;
          odrop_d = drop_q;
          ocnt_d  = cnt_q;
          st_d    = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_IDLE;
      old_q  <= '0;
      cnt_q  <= '0;
      ptr_q  <= '0;
      k_q    <= '0;
      stale_q <= '0;
      ov_q   <= 1'b0;
    end else begin
      st_q   <= st_d;
      old_q  <= old_d;
      cnt_q  <= cnt_d;
      ptr_q  <= ptr_d;
      k_q    <= k_d;
      stale_q <= stale_d;
      ov_q   <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q   <= now_d;
    drop_q  <= drop_d;
    any_q   <= any_d;
    quad_q  <= quad_d;
    cs_q    <= cs_d;
    ss_q    <= ss_d;
    mean_q  <= mean_d;
    oany_q  <= oany_d;
    odrop_q <= odrop_d;
    ocnt_q  <= ocnt_d;
  end

  assign out_if.valid          = ov_q;
  assign out_if.mean_heading   = mean_q;
  assign out_if.any_counted    = oany_q;
  assign out_if.samples_held   = ocnt_q;
  assign out_if.dropped_oldest = odrop_q;

endmodule
